/* hw/rtl/ugcb_pkg.sv */
// Package for the uniform grid broad phase: payload structs, request and
// register codes, divider result type. No dependencies.
`timescale 1ns / 1ps
package ugcb_pkg;

  localparam int unsigned DVW = 20;  // signed dividend width of the shared divider

  localparam logic [1:0] REQ_ADD     = 2'd0;
  localparam logic [1:0] REQ_SEARCH  = 2'd1;
  localparam logic [1:0] REQ_CLEAR   = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [2:0] CFG_FIELD_W = 3'd0;
  localparam logic [2:0] CFG_FIELD_H = 3'd1;
  localparam logic [2:0] CFG_SPAN_X  = 3'd2;
  localparam logic [2:0] CFG_SPAN_Y  = 3'd3;
  localparam logic [2:0] CFG_NONE    = 3'd5;  // not a register

  typedef struct packed {
    logic [1:0]         req_type;
    logic [5:0]         obj_key;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [14:0]        box_w;
    logic [14:0]        box_h;
    logic               exact_check;
  } in_t;

  typedef struct packed {
    logic [5:0] found_key;
    logic       found_valid;
    logic [6:0] hit_count;
    logic       overflow;
    logic       last;
  } out_t;

  typedef struct packed {
    logic [5:0]         key;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic [14:0]        w;
    logic [14:0]        h;
  } entry_t;

  typedef struct packed {
    logic signed [DVW-1:0] q_trunc;
    logic signed [DVW-1:0] q_floor;
    logic [14:0]           r_floor;
  } div_res_t;

endpackage

/* hw/rtl/ugcb_div.sv */
// Shared radix-2 restoring divider: signed dividend by unsigned 15-bit divisor.
// Gives truncating and flooring quotients plus floor remainder. Uses ugcb_pkg.
`timescale 1ns / 1ps
module ugcb_div import ugcb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [DVW-1:0] dividend_i,
  input  logic [14:0]           divisor_i,
  output logic                  done_o,
  output div_res_t              res_o
);

  localparam int unsigned CW = $clog2(DVW + 1);

  logic              busy_q, done_q, neg_q;
  logic [CW-1:0]     cnt_q;
  logic [14:0]       rem_q, dvs_q;
  logic [DVW-1:0]    quo_q;
  logic [15:0]       sh;
  logic              fits;
  logic signed [DVW-1:0] qt;
  logic              adj;

  assign sh   = {rem_q, quo_q[DVW-1]};
  assign fits = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVW-1];
      quo_q <= dividend_i[DVW-1] ? DVW'(-dividend_i) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? 15'(sh - {1'b0, dvs_q}) : sh[14:0];
      quo_q <= {quo_q[DVW-2:0], fits};
    end
  end

  assign qt  = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign adj = neg_q && (rem_q != '0);

  assign done_o        = done_q;
  assign res_o.q_trunc = qt;
  assign res_o.q_floor = adj ? qt - 1'b1 : qt;
  assign res_o.r_floor = adj ? dvs_q - rem_q : rem_q;

endmodule

/* hw/rtl/uniform_grid_collision_broadphase.sv */
// Uniform grid broad phase: a sequencer over cells and slots with one shared divider.
// Uses ugcb_pkg and ugcb_div.
`timescale 1ns / 1ps
// Usage:
//   in channel (in_valid_i/in_ready_o, in_i): one request per transfer: add a box
//   under a key, search keys near a box, or clear all cells.
//   out channel (out_valid_o/out_ready_i, out_o): one result per add, clear or
//   unknown code; a search returns one result per distinct key, ascending, or a
//   single empty result. The final result carries last.
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): writes a field
//   or span register, then re-derives the grid (two divisions) and
//   empties every cell. Write only while no request is in flight.
// Sequence: add and search run six divisions, then walk every cell of the grid,
//   reading its fill count; on add they write one slot per stored entry and the
//   fill count per touched cell; on search they read and check each stored slot
//   of a touched cell; emission steps through key indices up to the last found
//   key, holding while the result register is full. Clear and unknown codes go
//   straight to the response state, which loads the result register.
// One request at a time: in_ready_o stays low until the request is answered.
// The result register holds while out_ready_i is low; the sequencer waits on it.
// Reset restores 256x256 field, 16x16 cells, empty grid; no clearing pass needed.
module uniform_grid_collision_broadphase import ugcb_pkg::*; #(
  parameter int unsigned MAX_CELLS  = 256,
  parameter int unsigned CELL_SLOTS = 8,
  parameter int unsigned MAX_IDS    = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [14:0] cfg_data_i
);

  localparam int unsigned LCW   = $clog2(MAX_CELLS + 1);
  localparam int unsigned LIW   = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int unsigned FW    = $clog2(CELL_SLOTS + 1);
  localparam int unsigned DEPTH = MAX_CELLS * CELL_SLOTS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned IDW   = $clog2(MAX_IDS);
  localparam int unsigned RST_T = (MAX_CELLS < 256) ? MAX_CELLS : 256;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_GO, S_DIV_WAIT, S_MUL, S_TOTAL, S_CELL, S_FILL,
    S_ADD, S_SRD, S_SCHK, S_EMIT, S_RESP
  } state_e;

  typedef enum logic [2:0] {
    OP_CX1, OP_CX2, OP_CY1, OP_CY2, OP_HI, OP_LO, OP_COLS, OP_ROWS
  } op_e;

  state_e state_q;
  op_e    op_q;
  in_t    req_q;
  logic [14:0] fw_q, fh_q, sx_q, sy_q, cols_q, rows_q;
  logic [29:0] prod_q;
  logic [LCW-1:0] total_q, l_q;
  logic signed [DVW-1:0] cx1_q, cx2_q, cy1_q, cy2_q, hi_q, lo_q, m_q;
  logic [14:0] hi_rem_q, lo_rem_q;
  logic        vis_q, ovf_q;
  logic [FW-1:0] slot_q;
  logic [FW-1:0] fill_q;
  logic [MAX_CELLS-1:0] cvalid_q;
  logic        cv_rd_q;
  logic [MAX_IDS-1:0] hit_q;
  logic [6:0]  cnt_q, n_q;
  logic [IDW-1:0] idx_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [FW-1:0] fill_mem [MAX_CELLS];
  entry_t        ent_mem  [DEPTH];
  logic [FW-1:0] fill_rd_q;
  entry_t        ent_rd_q;

  // divider hookup
  logic                  div_start, div_done;
  logic signed [DVW-1:0] dvd;
  logic [14:0]           dvs;
  div_res_t              div_res;

  ugcb_div u_div (
    .clk_i,
    .rst_ni,
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  logic [14:0] sx_eff, sy_eff, fw_eff, fh_eff;
  logic signed [DVW-1:0] qx, qy, qhw, qhh, ql, qr, qt, qb;
  logic signed [DVW-1:0] ex, ey, ehw, ehh, el, er, et, eb;
  logic signed [DVW-1:0] lo_c, hi_c;
  logic [LIW-1:0] l_idx;
  logic [AW-1:0]  ent_addr;
  logic           out_free, out_load, last_cell, overlap_ok, add_wr, fill_wr;
  logic signed [DVW-1:0] hi_nxt, lo_nxt;
  logic [14:0]    hi_rem_nxt, lo_rem_nxt;
  logic [FW-1:0]  fill_cur;

  assign sx_eff = (sx_q == '0) ? 15'd1 : sx_q;
  assign sy_eff = (sy_q == '0) ? 15'd1 : sy_q;
  assign fw_eff = (fw_q == '0) ? 15'd1 : fw_q;
  assign fh_eff = (fh_q == '0) ? 15'd1 : fh_q;

  assign qx  = DVW'(req_q.center_x);
  assign qy  = DVW'(req_q.center_y);
  assign qhw = $signed({{(DVW-14){1'b0}}, req_q.box_w[14:1]});
  assign qhh = $signed({{(DVW-14){1'b0}}, req_q.box_h[14:1]});
  assign ql  = qx - qhw;
  assign qr  = qx + qhw;
  assign qt  = qy - qhh;
  assign qb  = qy + qhh;

  assign ex  = DVW'(ent_rd_q.cx);
  assign ey  = DVW'(ent_rd_q.cy);
  assign ehw = $signed({{(DVW-14){1'b0}}, ent_rd_q.w[14:1]});
  assign ehh = $signed({{(DVW-14){1'b0}}, ent_rd_q.h[14:1]});
  assign el  = ex - ehw;
  assign er  = ex + ehw;
  assign et  = ey - ehh;
  assign eb  = ey + ehh;

  assign overlap_ok = !req_q.exact_check ||
                      !((qr < el) || (er < ql) || (qb < et) || (eb < qt));

  always_comb begin
    dvd = '0;
    dvs = sx_eff;
    case (op_q)
      OP_CX1:  begin dvd = ql; dvs = sx_eff; end
      OP_CX2:  begin dvd = qr; dvs = sx_eff; end
      OP_CY1:  begin dvd = qt; dvs = sy_eff; end
      OP_CY2:  begin dvd = qb; dvs = sy_eff; end
      OP_HI:   begin dvd = -cx1_q; dvs = cols_q; end
      OP_LO:   begin
        dvd = $signed({{(DVW-15){1'b0}}, cols_q}) - DVW'(1) - cx2_q;
        dvs = cols_q;
      end
      OP_COLS: begin dvd = $signed({{(DVW-15){1'b0}}, 15'(fw_eff - 1'b1)}); dvs = sx_eff; end
      OP_ROWS: begin dvd = $signed({{(DVW-15){1'b0}}, 15'(fh_eff - 1'b1)}); dvs = sy_eff; end
      default: begin dvd = '0; dvs = sx_eff; end
    endcase
  end

  assign div_start = (state_q == S_DIV_GO);

  // per-cell row window: rows r with cx1 <= L - r*cols <= cx2, clamped to [cy1, cy2]
  assign lo_c = (lo_q > cy1_q) ? lo_q : cy1_q;
  assign hi_c = (hi_q < cy2_q) ? hi_q : cy2_q;

  // floor quotients advance by one step of L through their remainders
  assign hi_rem_nxt = ({1'b0, hi_rem_q} + 16'd1 == {1'b0, cols_q}) ? '0 : 15'(hi_rem_q + 1'b1);
  assign hi_nxt     = ({1'b0, hi_rem_q} + 16'd1 == {1'b0, cols_q}) ? hi_q + 1'b1 : hi_q;
  assign lo_rem_nxt = ({1'b0, lo_rem_q} + 16'd1 == {1'b0, cols_q}) ? '0 : 15'(lo_rem_q + 1'b1);
  assign lo_nxt     = ({1'b0, lo_rem_q} + 16'd1 == {1'b0, cols_q}) ? lo_q + 1'b1 : lo_q;

  assign l_idx     = l_q[LIW-1:0];
  assign last_cell = (l_q + 1'b1) == total_q;
  assign ent_addr  = AW'(l_idx) * AW'(CELL_SLOTS) + AW'(slot_q);
  assign fill_cur  = cv_rd_q ? fill_rd_q : '0;
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = out_free && (((state_q == S_EMIT) && hit_q[idx_q]) ||
                                  (state_q == S_RESP));

  assign add_wr  = (state_q == S_ADD) && (m_q != '0) && (slot_q != FW'(CELL_SLOTS));
  assign fill_wr = (state_q == S_ADD) && ((m_q == '0) || (slot_q == FW'(CELL_SLOTS)));

  always_ff @(posedge clk_i) begin
    if (add_wr) begin
      ent_mem[ent_addr] <= '{key: req_q.obj_key, cx: req_q.center_x, cy: req_q.center_y,
                             w: req_q.box_w, h: req_q.box_h};
    end
    if (fill_wr) begin
      fill_mem[l_idx] <= slot_q;
    end
    ent_rd_q  <= ent_mem[ent_addr];
    fill_rd_q <= fill_mem[l_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_CX1;
      req_q       <= '0;
      fw_q        <= 15'd256;
      fh_q        <= 15'd256;
      sx_q        <= 15'd16;
      sy_q        <= 15'd16;
      cols_q      <= 15'd16;
      rows_q      <= 15'd16;
      prod_q      <= 30'd256;
      total_q     <= LCW'(RST_T);
      l_q         <= '0;
      cx1_q       <= '0;
      cx2_q       <= '0;
      cy1_q       <= '0;
      cy2_q       <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      hi_rem_q    <= '0;
      lo_rem_q    <= '0;
      m_q         <= '0;
      vis_q       <= 1'b0;
      ovf_q       <= 1'b0;
      slot_q      <= '0;
      fill_q      <= '0;
      cvalid_q    <= '0;
      cv_rd_q     <= 1'b0;
      hit_q       <= '0;
      cnt_q       <= '0;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      cv_rd_q <= cvalid_q[l_idx];
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cfg_valid_i) begin
            case (cfg_index_i)
              CFG_FIELD_W: begin fw_q <= cfg_data_i; op_q <= OP_COLS; state_q <= S_DIV_GO; end
              CFG_FIELD_H: begin fh_q <= cfg_data_i; op_q <= OP_COLS; state_q <= S_DIV_GO; end
              CFG_SPAN_X:  begin sx_q <= cfg_data_i; op_q <= OP_COLS; state_q <= S_DIV_GO; end
              CFG_SPAN_Y:  begin sy_q <= cfg_data_i; op_q <= OP_COLS; state_q <= S_DIV_GO; end
              default:     state_q <= S_IDLE;
            endcase
          end else if (in_valid_i) begin
            req_q <= in_i;
            ovf_q <= 1'b0;
            hit_q <= '0;
            cnt_q <= '0;
            n_q   <= '0;
            idx_q <= '0;
            op_q  <= OP_CX1;
            case (in_i.req_type)
              REQ_ADD: begin
                state_q <= ({1'b0, in_i.obj_key} < 7'(MAX_IDS)) ? S_DIV_GO : S_RESP;
              end
              REQ_SEARCH: state_q <= S_DIV_GO;
              REQ_CLEAR: begin
                cvalid_q <= '0;
                state_q  <= S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_DIV_GO: state_q <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            case (op_q)
              OP_CX1:  cx1_q <= div_res.q_trunc;
              OP_CX2:  cx2_q <= div_res.q_trunc;
              OP_CY1:  cy1_q <= div_res.q_trunc;
              OP_CY2:  cy2_q <= div_res.q_trunc;
              OP_HI:   begin hi_q <= div_res.q_floor; hi_rem_q <= div_res.r_floor; end
              OP_LO:   begin lo_q <= div_res.q_floor; lo_rem_q <= div_res.r_floor; end
              OP_COLS: cols_q <= 15'(div_res.q_trunc + 1'b1);
              OP_ROWS: rows_q <= 15'(div_res.q_trunc + 1'b1);
              default: cols_q <= cols_q;
            endcase
            if (op_q == OP_LO) begin
              l_q     <= '0;
              state_q <= S_CELL;
            end else if (op_q == OP_ROWS) begin
              state_q <= S_MUL;
            end else begin
              op_q    <= op_e'(op_q + 1'b1);
              state_q <= S_DIV_GO;
            end
          end
        end
        S_MUL: begin
          prod_q  <= cols_q * rows_q;
          state_q <= S_TOTAL;
        end
        S_TOTAL: begin
          total_q  <= (prod_q > 30'(MAX_CELLS)) ? LCW'(MAX_CELLS) : LCW'(prod_q);
          cvalid_q <= '0;
          state_q  <= S_IDLE;
        end
        S_CELL: begin
          vis_q   <= hi_c >= lo_c;
          m_q     <= hi_c - lo_c + 1'b1;
          state_q <= S_FILL;
        end
        S_FILL: begin
          fill_q <= fill_cur;
          if (!vis_q) begin
            l_q      <= l_q + 1'b1;
            hi_q     <= hi_nxt;
            hi_rem_q <= hi_rem_nxt;
            lo_q     <= lo_nxt;
            lo_rem_q <= lo_rem_nxt;
            if (last_cell) begin
              state_q <= (req_q.req_type == REQ_ADD || cnt_q == '0) ? S_RESP : S_EMIT;
            end else begin
              state_q <= S_CELL;
            end
          end else if (req_q.req_type == REQ_ADD) begin
            slot_q  <= fill_cur;
            state_q <= S_ADD;
          end else begin
            slot_q  <= '0;
            state_q <= S_SRD;
          end
        end
        S_ADD: begin
          if (fill_wr) begin
            cvalid_q[l_idx] <= 1'b1;
            if (m_q != '0) begin
              ovf_q <= 1'b1;
            end
            l_q      <= l_q + 1'b1;
            hi_q     <= hi_nxt;
            hi_rem_q <= hi_rem_nxt;
            lo_q     <= lo_nxt;
            lo_rem_q <= lo_rem_nxt;
            state_q  <= last_cell ? S_RESP : S_CELL;
          end else begin
            slot_q <= slot_q + 1'b1;
            m_q    <= m_q - 1'b1;
          end
        end
        S_SRD: begin
          if (slot_q == fill_q) begin
            l_q      <= l_q + 1'b1;
            hi_q     <= hi_nxt;
            hi_rem_q <= hi_rem_nxt;
            lo_q     <= lo_nxt;
            lo_rem_q <= lo_rem_nxt;
            if (last_cell) begin
              state_q <= (cnt_q == '0) ? S_RESP : S_EMIT;
            end else begin
              state_q <= S_CELL;
            end
          end else begin
            state_q <= S_SCHK;
          end
        end
        S_SCHK: begin
          if (overlap_ok && !hit_q[ent_rd_q.key[IDW-1:0]]) begin
            hit_q[ent_rd_q.key[IDW-1:0]] <= 1'b1;
            cnt_q <= cnt_q + 1'b1;
          end
          slot_q  <= slot_q + 1'b1;
          state_q <= S_SRD;
        end
        S_EMIT: begin
          if (!hit_q[idx_q]) begin
            idx_q <= idx_q + 1'b1;
          end else if (out_free) begin
            out_q       <= '{found_key: 6'(idx_q), found_valid: 1'b1, hit_count: cnt_q,
                             overflow: 1'b0, last: (n_q + 1'b1) == cnt_q};
            n_q         <= n_q + 1'b1;
            idx_q       <= idx_q + 1'b1;
            if ((n_q + 1'b1) == cnt_q) begin
              state_q <= S_IDLE;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_q       <= '{found_key: 6'd0, found_valid: 1'b0, hit_count: 7'd0,
                             overflow: ovf_q, last: 1'b1};
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  a_empty_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.found_valid |-> out_o.last && out_o.hit_count == 7'd0)
    else $error("empty result must be final with zero count");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 7'(MAX_IDS))
    else $error("hit count exceeds key space");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ADD |-> slot_q <= FW'(CELL_SLOTS))
    else $error("slot pointer past cell capacity");

  a_emit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && out_free && hit_q[idx_q] |=> out_valid_q && out_q.found_valid)
    else $error("found key not presented");
`endif

endmodule

/* tb/uniform_grid_collision_broadphase_tb.sv */
// Self-checking bench for the uniform grid broad phase: random and directed
// add/search/clear traffic over several grid settings. Depends on ugcb_pkg.
`timescale 1ns / 1ps
module uniform_grid_collision_broadphase_tb;
  import ugcb_pkg::*;

  localparam int NCELL = 256;
  localparam int NSLOT = 8;
  localparam int WDOG_LIMIT = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_t         in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_t        out_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [14:0] cfg_data_i = '0;

  uniform_grid_collision_broadphase dut (.*);

  initial forever #1 clk_i = ~clk_i;

  // grid model
  logic [14:0] fw_q = 15'd256, fh_q = 15'd256, sx_q = 15'd16, sy_q = 15'd16;
  longint      cols_m, rows_m, ncell_m;
  entry_t      slot_m [NCELL][NSLOT];
  int          fill_m [NCELL];

  in_t  pending_reqs[$];
  out_t expected_results[$];
  int   fails = 0;
  int   idle_mode = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  int   wdog = 0;

  function automatic void queue_req(in_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void expect_out(out_t o);
    expected_results.insert(expected_results.size(), o);
  endfunction

  function automatic longint nz(logic [14:0] v);
    return (v == 0) ? 1 : longint'(v);
  endfunction

  function automatic longint floor_div(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic void rebuild_grid();
    longint t;
    cols_m = (nz(fw_q) - 1) / nz(sx_q) + 1;
    rows_m = (nz(fh_q) - 1) / nz(sy_q) + 1;
    t = cols_m * rows_m;
    ncell_m = (t > NCELL) ? NCELL : t;
    foreach (fill_m[i]) fill_m[i] = 0;
  endfunction

  function automatic void write_reg_model(logic [2:0] idx, logic [14:0] val);
    case (idx)
      CFG_FIELD_W: fw_q = val;
      CFG_FIELD_H: fh_q = val;
      CFG_SPAN_X:  sx_q = val;
      CFG_SPAN_Y:  sy_q = val;
      default: return;
    endcase
    rebuild_grid();
  endfunction

  // how many (col,row) pairs of the box range land on linear cell lin
  function automatic longint pair_hits(longint lin, longint c1, longint c2,
                                       longint r1, longint r2);
    longint lo, hi;
    lo = -floor_div(-(lin - c2), cols_m);
    hi = floor_div(lin - c1, cols_m);
    if (lo < r1) lo = r1;
    if (hi > r2) hi = r2;
    return (hi >= lo) ? hi - lo + 1 : 0;
  endfunction

  function automatic bit boxes_touch(longint x1, longint y1, longint w1, longint h1,
                                     longint x2, longint y2, longint w2, longint h2);
    return !((x1 + w1/2 < x2 - w2/2) || (x2 + w2/2 < x1 - w1/2) ||
             (y1 + h1/2 < y2 - h2/2) || (y2 + h2/2 < y1 - h1/2));
  endfunction

  function automatic void predict_request(in_t r);
    longint x, y, w, h, c1, c2, r1, r2, m;
    logic [63:0] hits;
    int   cnt, n;
    out_t o;
    entry_t e;
    x = r.center_x; y = r.center_y; w = r.box_w; h = r.box_h;
    c1 = (x - w/2) / nz(sx_q); c2 = (x + w/2) / nz(sx_q);
    r1 = (y - h/2) / nz(sy_q); r2 = (y + h/2) / nz(sy_q);
    o = '0;
    o.last = 1'b1;
    if (r.req_type == REQ_ADD) begin
      e.key = r.obj_key; e.cx = r.center_x; e.cy = r.center_y;
      e.w = r.box_w; e.h = r.box_h;
      for (longint l = 0; l < ncell_m; l++) begin
        m = pair_hits(l, c1, c2, r1, r2);
        while (m > 0) begin
          if (fill_m[l] >= NSLOT) begin
            o.overflow = 1'b1;
            break;
          end
          slot_m[l][fill_m[l]] = e;
          fill_m[l]++;
          m--;
        end
      end
      expect_out(o);
    end else if (r.req_type == REQ_SEARCH) begin
      hits = '0;
      for (longint l = 0; l < ncell_m; l++) begin
        if (pair_hits(l, c1, c2, r1, r2) == 0) continue;
        for (int i = 0; i < fill_m[l]; i++) begin
          e = slot_m[l][i];
          if (!r.exact_check || boxes_touch(x, y, w, h, e.cx, e.cy, e.w, e.h))
            hits[e.key] = 1'b1;
        end
      end
      cnt = $countones(hits);
      if (cnt == 0) expect_out(o);
      n = 0;
      for (int k = 0; k < 64; k++) begin
        if (hits[k]) begin
          n++;
          o.found_key = k[5:0]; o.found_valid = 1'b1;
          o.hit_count = cnt[6:0]; o.last = (n == cnt);
          expect_out(o);
        end
      end
    end else begin
      if (r.req_type == REQ_CLEAR) foreach (fill_m[i]) fill_m[i] = 0;
      expect_out(o);
    end
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict_request(in_i);
      if (pending_reqs.size() > 0 &&
          !((idle_mode == 1 && $urandom_range(0, 99) < 65) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 34))) begin
        in_valid_i <= 1'b1;
        in_i <= pending_reqs.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_o);
          fails++;
        end else begin
          want = expected_results.pop_front();
          if (out_o !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, out_o);
            fails++;
          end
        end
      end
      out_ready_i <= !((idle_mode == 2 && $urandom_range(0, 99) < 65) ||
                       (idle_mode == 3 && $urandom_range(0, 99) < 34));
    end
  end

  // watchdog on transfers of any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      wdog <= 0;
    else if (rst_ni) begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_t make_req(logic [1:0] t, logic [5:0] k, int x, int y,
                                   int w, int h, bit ex);
    in_t r;
    r.req_type = t; r.obj_key = k; r.center_x = x[15:0]; r.center_y = y[15:0];
    r.box_w = w[14:0]; r.box_h = h[14:0]; r.exact_check = ex;
    return r;
  endfunction

  function automatic int clip_coord(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic in_t random_req();
    int   p;
    logic [1:0] t;
    longint x, y, w, h;
    p = $urandom_range(0, 99);
    t = (p < 50) ? REQ_ADD : (p < 93) ? REQ_SEARCH : (p < 97) ? REQ_CLEAR : REQ_UNKNOWN;
    if ($urandom_range(0, 99) < 85) begin
      x = longint'($urandom_range(0, nz(fw_q) + 2*nz(sx_q))) - nz(sx_q);
      y = longint'($urandom_range(0, nz(fh_q) + 2*nz(sy_q))) - nz(sy_q);
    end else begin
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
    end
    if ($urandom_range(0, 99) < 80) begin
      w = $urandom_range(0, 3 * nz(sx_q));
      h = $urandom_range(0, 3 * nz(sy_q));
      if (w > 32767) w = 32767;
      if (h > 32767) h = 32767;
    end else begin
      w = $urandom_range(0, 32767);
      h = $urandom_range(0, 32767);
    end
    return make_req(t, 6'($urandom), clip_coord(x), clip_coord(y), int'(w), int'(h),
                    1'($urandom_range(0, 1)));
  endfunction

  task automatic wait_quiet();
    while (pending_reqs.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    write_reg_model(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // field w, field h, span x, span y per phase
  int grid_set [6][4] = '{
    '{256, 256, 16, 16}, '{100, 60, 10, 7}, '{32767, 32767, 32767, 32767},
    '{32767, 32767, 1, 1}, '{0, 0, 0, 0}, '{200, 150, 13, 9}};

  initial begin
    rebuild_grid();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty search, repeated cell, full cell, extremes, unknown code
    queue_req(make_req(REQ_SEARCH, 6'd0, 0, 0, 0, 0, 1'b0));
    queue_req(make_req(REQ_ADD, 6'd0, 0, 0, 0, 0, 1'b0));
    queue_req(make_req(REQ_ADD, 6'd63, 32767, 32767, 32767, 32767, 1'b1));
    queue_req(make_req(REQ_ADD, 6'd21, -32768, -32768, 0, 0, 1'b0));
    queue_req(make_req(REQ_ADD, 6'd42, -128, 8, 256, 16, 1'b0));
    queue_req(make_req(REQ_SEARCH, 6'd0, 0, 0, 2, 2, 1'b0));
    queue_req(make_req(REQ_SEARCH, 6'd0, 0, 0, 2, 2, 1'b1));
    for (int k = 1; k <= 9; k++)
      queue_req(make_req(REQ_ADD, k[5:0], 40, 40, 4, 4, 1'b0));
    queue_req(make_req(REQ_SEARCH, 6'd0, 40, 40, 0, 0, 1'b1));
    queue_req(make_req(REQ_SEARCH, 6'd0, 128, 128, 32767, 32767, 1'b0));
    queue_req(make_req(REQ_UNKNOWN, 6'd63, -1, -1, 32767, 32767, 1'b1));
    queue_req(make_req(REQ_CLEAR, 6'd0, 0, 0, 0, 0, 1'b0));
    queue_req(make_req(REQ_SEARCH, 6'd0, 40, 40, 100, 100, 1'b0));

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      idle_mode = ph % 4;
      write_reg(CFG_FIELD_W, grid_set[ph][0][14:0]);
      write_reg(CFG_FIELD_H, grid_set[ph][1][14:0]);
      write_reg(CFG_SPAN_X, grid_set[ph][2][14:0]);
      write_reg(CFG_SPAN_Y, grid_set[ph][3][14:0]);
      if (ph == 5) write_reg(CFG_NONE, 15'h7fff);  // unused index, no effect
      for (int i = 0; i < 85; i++) queue_req(random_req());
    end

    wait_quiet();
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ugcb_pkg.sv
hw/rtl/ugcb_div.sv
hw/rtl/uniform_grid_collision_broadphase.sv
tb/uniform_grid_collision_broadphase_tb.sv
